@@ rtl/core/dam_pkg.sv @@
// Shared widths, word constants and arithmetic unit types for the decimal accumulator machine.
`default_nettype none

package dam_pkg;

    localparam int MODE_W   = 2;
    localparam int DATA_W   = 16;
    localparam int WORD_W   = 15;
    localparam int MAG_W    = 14;
    localparam int PC_W     = 7;
    localparam int STATUS_W = 4;

    localparam logic signed [WORD_W-1:0] WORD_MAX  = 15'sd9999;
    localparam logic signed [WORD_W-1:0] WORD_MIN  = -15'sd9999;
    localparam logic signed [WORD_W-1:0] WORD_INIT = 15'sd4444;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 4'd0,
        ST_HALTED     = 4'd1,
        ST_TOO_LARGE  = 4'd2,
        ST_BAD_WORD   = 4'd3,
        ST_BAD_INPUT  = 4'd4,
        ST_OVERFLOW   = 4'd5,
        ST_UNDERFLOW  = 4'd6,
        ST_DIV_ZERO   = 4'd7,
        ST_BAD_OPCODE = 4'd8,
        ST_ADDRESS    = 4'd9
    } t_status;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic                     start;
        t_alu_op                  op;
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic                     done;
        logic                     over;
        logic                     under;
        logic signed [WORD_W-1:0] value;
    } t_alu_rsp;

endpackage

`default_nettype wire

@@ rtl/core/dam_if.sv @@
// Handshake interfaces for the input item channel and the result channel.
`default_nettype none

interface dam_in_if;
    import dam_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] data_word;

    modport source (output valid, output mode, output data_word, input ready);
    modport sink (input valid, input mode, input data_word, output ready);
endinterface

interface dam_out_if;
    import dam_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic                     out_valid;
    logic signed [WORD_W-1:0] out_word;
    logic signed [WORD_W-1:0] acc_value;
    logic [PC_W-1:0]          pc_value;

    modport source (
        output valid, output status, output out_valid, output out_word,
        output acc_value, output pc_value, input ready
    );
    modport sink (
        input valid, input status, input out_valid, input out_word,
        input acc_value, input pc_value, output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/dam_mem.sv @@
// Word store with registered read and per-entry valid bits that read as the reset word.
`default_nettype none

module dam_mem #(
    parameter int MEM_WORDS = 100,
    localparam int ADDR_W = $clog2(MEM_WORDS)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_rd_en,
    input  wire logic [ADDR_W-1:0]                 i_rd_addr,
    output logic signed [dam_pkg::WORD_W-1:0]      o_rd_data,
    input  wire logic                              i_wr_en,
    input  wire logic [ADDR_W-1:0]                 i_wr_addr,
    input  wire logic signed [dam_pkg::WORD_W-1:0] i_wr_data
);
    import dam_pkg::*;

    logic signed [WORD_W-1:0] r_mem [MEM_WORDS];
    logic [MEM_WORDS-1:0]     r_valid;
    logic signed [WORD_W-1:0] r_rd_word;
    logic                     r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_word <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_word : WORD_INIT;

endmodule

`default_nettype wire

@@ rtl/core/dam_alu.sv @@
// Shared arithmetic unit: add and subtract computed directly on request, bit-serial multiply and divide.
`default_nettype none

module dam_alu (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dam_pkg::t_alu_req i_req,
    output dam_pkg::t_alu_rsp      o_rsp
);
    import dam_pkg::*;

    localparam int PROD_W = 2 * MAG_W;
    localparam int CNT_W  = $clog2(MAG_W);
    localparam logic [PROD_W-1:0]      MAG_MAX = PROD_W'(WORD_MAX);
    localparam logic signed [WORD_W:0] SUM_MAX = (WORD_W+1)'(WORD_MAX);
    localparam logic signed [WORD_W:0] SUM_MIN = (WORD_W+1)'(WORD_MIN);

    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_FIN
    } t_state;

    t_state                   r_state;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_neg;
    logic                     r_is_div;
    logic [MAG_W-1:0]         r_mb;
    logic [MAG_W-1:0]         r_aux;
    logic [MAG_W-1:0]         r_rem;
    logic [PROD_W-1:0]        r_prod;
    logic [PROD_W-1:0]        r_mcand;
    logic                     r_done;
    logic                     r_over;
    logic                     r_under;
    logic signed [WORD_W-1:0] r_value;

    logic [WORD_W-1:0]        a_abs;
    logic [WORD_W-1:0]        b_abs;
    logic signed [WORD_W:0]   sum;
    logic [PROD_W-1:0]        mul_sum;
    logic [MAG_W:0]           rem_sh;
    logic                     rem_ge;
    logic [MAG_W-1:0]         rem_next;
    logic [PROD_W-1:0]        fin_mag;
    logic [WORD_W-1:0]        fin_abs;

    assign a_abs = i_req.a[WORD_W-1] ? WORD_W'(-i_req.a) : WORD_W'(i_req.a);
    assign b_abs = i_req.b[WORD_W-1] ? WORD_W'(-i_req.b) : WORD_W'(i_req.b);
    assign sum = (i_req.op == ALU_SUB) ?
                 (WORD_W+1)'(i_req.a) - (WORD_W+1)'(i_req.b) :
                 (WORD_W+1)'(i_req.a) + (WORD_W+1)'(i_req.b);

    assign mul_sum  = r_aux[0] ? r_prod + r_mcand : r_prod;
    assign rem_sh   = {r_rem, r_aux[MAG_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_mb};
    assign rem_next = rem_ge ? MAG_W'(rem_sh - {1'b0, r_mb}) : rem_sh[MAG_W-1:0];
    assign fin_mag  = r_is_div ? PROD_W'(r_aux) : r_prod;
    assign fin_abs  = fin_mag[WORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        r_neg   <= i_req.a[WORD_W-1] ^ i_req.b[WORD_W-1];
                        r_cnt   <= CNT_W'(MAG_W - 1);
                        r_mb    <= b_abs[MAG_W-1:0];
                        r_rem   <= '0;
                        r_prod  <= '0;
                        r_mcand <= PROD_W'(a_abs[MAG_W-1:0]);
                        case (i_req.op)
                            ALU_MUL: begin
                                r_aux    <= b_abs[MAG_W-1:0];
                                r_is_div <= 1'b0;
                                r_state  <= A_MUL;
                            end
                            ALU_DIV: begin
                                r_aux    <= a_abs[MAG_W-1:0];
                                r_is_div <= 1'b1;
                                r_state  <= A_DIV;
                            end
                            default: begin
                                r_done  <= 1'b1;
                                r_over  <= sum > SUM_MAX;
                                r_under <= sum < SUM_MIN;
                                r_value <= WORD_W'(sum);
                            end
                        endcase
                    end
                end
                A_MUL: begin
                    r_prod  <= mul_sum;
                    r_mcand <= r_mcand << 1;
                    r_aux   <= r_aux >> 1;
                    if (r_cnt == '0) begin
                        r_state <= A_FIN;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                A_DIV: begin
                    r_rem <= rem_next;
                    r_aux <= {r_aux[MAG_W-2:0], rem_ge};
                    if (r_cnt == '0) begin
                        r_state <= A_FIN;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                A_FIN: begin
                    r_done  <= 1'b1;
                    r_over  <= !r_neg && (fin_mag > MAG_MAX);
                    r_under <= r_neg && (fin_mag > MAG_MAX);
                    r_value <= r_neg ? $signed(WORD_W'(-fin_abs)) : $signed(fin_abs);
                    r_state <= A_IDLE;
                end
                default: begin
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.over  = r_over;
    assign o_rsp.under = r_under;
    assign o_rsp.value = r_value;

`ifndef SYNTH
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("Arithmetic done held for more than one cycle.");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !(r_over && r_under))
        else $error("Overflow and underflow flagged together.");

    a_value_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !r_over && !r_under) |-> (r_value <= WORD_MAX && r_value >= WORD_MIN))
        else $error("Accepted arithmetic result lies outside the word range.");
`endif

endmodule

`default_nettype wire

@@ rtl/core/decimal_accumulator_machine_top.sv @@
// Top level of the decimal accumulator machine: instruction sequencer, word store and arithmetic unit.
`default_nettype none

// Each input transaction is one load, start or step command, and each yields exactly one result
// transaction. The block takes one command at a time: ready is high only while the sequencer
// is idle, and a finished result waits in an output register so the next command can be taken
// before it is read. A load, a start, or any command on a stopped machine passes only through
// dispatch and response; a step adds fetch and decode, through the word store's registered read
// port, for read, store, branch and halt, an operand read for write and load, and for add and
// subtract, multiply and divide also a wait on the shared arithmetic unit, where multiply and
// divide run 14 shift-add or restore-subtract iterations. The word store keeps a valid bit per
// entry, so it reads as 4444 right after reset with no clearing pass.
module decimal_accumulator_machine_top #(
    parameter int MEM_WORDS = 100
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    dam_in_if.sink    i_in,
    dam_out_if.source o_out
);
    import dam_pkg::*;

    localparam int ADDR_W   = $clog2(MEM_WORDS);
    localparam int RECIP_W  = 13;
    localparam int RECIP_SH = 19;
    localparam int QPROD_W  = MAG_W + RECIP_W;
    localparam logic [QPROD_W-1:0] RECIP = QPROD_W'(5243);
    localparam logic [PC_W-1:0]    RADIX = PC_W'(100);
    localparam logic [PC_W-1:0]    PC_END = PC_W'(MEM_WORDS);
    localparam logic signed [DATA_W-1:0] DATA_MAX = DATA_W'(WORD_MAX);
    localparam logic signed [DATA_W-1:0] DATA_MIN = DATA_W'(WORD_MIN);

    localparam logic [MODE_W-1:0] MODE_LOAD  = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_START = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_STEP  = MODE_W'(2);

    localparam logic [PC_W-1:0] OP_READ       = PC_W'(10);
    localparam logic [PC_W-1:0] OP_WRITE      = PC_W'(11);
    localparam logic [PC_W-1:0] OP_LOAD       = PC_W'(20);
    localparam logic [PC_W-1:0] OP_STORE      = PC_W'(21);
    localparam logic [PC_W-1:0] OP_ADD        = PC_W'(30);
    localparam logic [PC_W-1:0] OP_SUBTRACT   = PC_W'(31);
    localparam logic [PC_W-1:0] OP_DIVIDE     = PC_W'(32);
    localparam logic [PC_W-1:0] OP_MULTIPLY   = PC_W'(33);
    localparam logic [PC_W-1:0] OP_BRANCH     = PC_W'(40);
    localparam logic [PC_W-1:0] OP_BRANCHNEG  = PC_W'(41);
    localparam logic [PC_W-1:0] OP_BRANCHZERO = PC_W'(42);
    localparam logic [PC_W-1:0] OP_HALT       = PC_W'(43);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_FETCH,
        S_DECODE,
        S_OPER,
        S_WAIT,
        S_RESP
    } t_state;

    t_state                   r_state, n_state;
    logic [MODE_W-1:0]        r_mode, n_mode;
    logic signed [DATA_W-1:0] r_data, n_data;
    logic signed [WORD_W-1:0] r_acc, n_acc;
    logic [PC_W-1:0]          r_pc, n_pc;
    t_status                  r_stop, n_stop;
    logic [PC_W-1:0]          r_op, n_op;
    logic                     r_neg, n_neg;
    logic [MAG_W-1:0]         r_mag, n_mag;
    t_status                  r_res_status, n_res_status;
    logic                     r_res_valid, n_res_valid;
    logic signed [WORD_W-1:0] r_res_word, n_res_word;
    logic                     r_out_vld, n_out_vld;
    t_status                  r_o_status, n_o_status;
    logic                     r_o_valid, n_o_valid;
    logic signed [WORD_W-1:0] r_o_word, n_o_word;
    logic signed [WORD_W-1:0] r_o_acc, n_o_acc;
    logic [PC_W-1:0]          r_o_pc, n_o_pc;

    logic                     mem_rd_en;
    logic [ADDR_W-1:0]        mem_rd_addr;
    logic signed [WORD_W-1:0] mem_rd_data;
    logic                     mem_wr_en;
    logic [ADDR_W-1:0]        mem_wr_addr;
    logic signed [WORD_W-1:0] mem_wr_data;
    t_alu_req                 alu_req;
    t_alu_rsp                 alu_rsp;

    logic                     do_stop;
    t_status                  stop_code;
    logic                     data_ok;
    logic signed [WORD_W-1:0] data_word;
    logic [PC_W-1:0]          pc_inc;
    logic                     fetch_neg;
    logic [WORD_W-1:0]        fetch_abs;
    logic [QPROD_W-1:0]       fetch_prod;
    logic [MAG_W-1:0]         dec_rem;
    logic [PC_W-1:0]          dec_addr;

    dam_mem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    dam_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    assign data_ok    = (r_data >= DATA_MIN) && (r_data <= DATA_MAX);
    assign data_word  = $signed(r_data[WORD_W-1:0]);
    assign pc_inc     = r_pc + PC_W'(1);
    assign fetch_neg  = mem_rd_data[WORD_W-1];
    assign fetch_abs  = fetch_neg ? WORD_W'(-mem_rd_data) : WORD_W'(mem_rd_data);
    assign fetch_prod = QPROD_W'(fetch_abs[MAG_W-1:0]) * RECIP;
    assign dec_rem    = r_mag - MAG_W'(r_op) * MAG_W'(RADIX);
    assign dec_addr   = dec_rem[PC_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_data       = r_data;
        n_acc        = r_acc;
        n_pc         = r_pc;
        n_stop       = r_stop;
        n_op         = r_op;
        n_neg        = r_neg;
        n_mag        = r_mag;
        n_res_status = r_res_status;
        n_res_valid  = r_res_valid;
        n_res_word   = r_res_word;
        n_out_vld    = r_out_vld && !o_out.ready;
        n_o_status   = r_o_status;
        n_o_valid    = r_o_valid;
        n_o_word     = r_o_word;
        n_o_acc      = r_o_acc;
        n_o_pc       = r_o_pc;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = r_pc[ADDR_W-1:0];
        mem_wr_en    = 1'b0;
        mem_wr_addr  = r_pc[ADDR_W-1:0];
        mem_wr_data  = r_acc;
        alu_req.start = 1'b0;
        alu_req.op    = ALU_ADD;
        alu_req.a     = r_acc;
        alu_req.b     = mem_rd_data;
        do_stop      = 1'b0;
        stop_code    = ST_OK;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_mode       = i_in.mode;
                    n_data       = i_in.data_word;
                    n_res_status = ST_OK;
                    n_res_valid  = 1'b0;
                    n_res_word   = '0;
                    n_state      = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state      = S_RESP;
                n_res_status = r_stop;
                case (r_mode)
                    MODE_START: begin
                        n_pc = '0;
                        if (!(r_stop inside {ST_TOO_LARGE, ST_BAD_WORD})) begin
                            n_stop       = ST_OK;
                            n_res_status = ST_OK;
                        end
                    end
                    MODE_LOAD: begin
                        if (r_stop == ST_OK) begin
                            if (r_pc >= PC_END) begin
                                do_stop   = 1'b1;
                                stop_code = ST_TOO_LARGE;
                            end else if (!data_ok) begin
                                do_stop   = 1'b1;
                                stop_code = ST_BAD_WORD;
                            end else begin
                                mem_wr_en   = 1'b1;
                                mem_wr_data = data_word;
                                n_pc        = pc_inc;
                            end
                        end
                    end
                    MODE_STEP: begin
                        if (r_stop == ST_OK) begin
                            if (r_pc >= PC_END) begin
                                do_stop   = 1'b1;
                                stop_code = ST_ADDRESS;
                            end else begin
                                mem_rd_en = 1'b1;
                                n_state   = S_FETCH;
                            end
                        end
                    end
                    default: begin
                        n_res_status = r_stop;
                    end
                endcase
            end
            S_FETCH: begin
                n_neg   = fetch_neg;
                n_mag   = fetch_abs[MAG_W-1:0];
                n_op    = fetch_prod[RECIP_SH +: PC_W];
                n_state = S_DECODE;
            end
            S_DECODE: begin
                n_state = S_RESP;
                if (r_neg) begin
                    do_stop   = 1'b1;
                    stop_code = ST_BAD_OPCODE;
                end else if (r_op == OP_HALT) begin
                    do_stop   = 1'b1;
                    stop_code = ST_HALTED;
                end else if (!(r_op inside {OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD,
                                            OP_SUBTRACT, OP_DIVIDE, OP_MULTIPLY, OP_BRANCH,
                                            OP_BRANCHNEG, OP_BRANCHZERO})) begin
                    do_stop   = 1'b1;
                    stop_code = ST_BAD_OPCODE;
                end else if (dec_addr >= PC_END) begin
                    do_stop   = 1'b1;
                    stop_code = ST_ADDRESS;
                end else begin
                    case (r_op)
                        OP_READ: begin
                            if (!data_ok) begin
                                do_stop   = 1'b1;
                                stop_code = ST_BAD_INPUT;
                            end else begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = dec_addr[ADDR_W-1:0];
                                mem_wr_data = data_word;
                                n_res_valid = 1'b1;
                                n_res_word  = data_word;
                                n_pc        = pc_inc;
                            end
                        end
                        OP_STORE: begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = dec_addr[ADDR_W-1:0];
                            mem_wr_data = r_acc;
                            n_pc        = pc_inc;
                        end
                        OP_BRANCH: begin
                            n_pc = dec_addr;
                        end
                        OP_BRANCHNEG: begin
                            n_pc = r_acc[WORD_W-1] ? dec_addr : pc_inc;
                        end
                        OP_BRANCHZERO: begin
                            n_pc = (r_acc == '0) ? dec_addr : pc_inc;
                        end
                        default: begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = dec_addr[ADDR_W-1:0];
                            n_state     = S_OPER;
                        end
                    endcase
                end
            end
            S_OPER: begin
                n_state = S_RESP;
                case (r_op)
                    OP_WRITE: begin
                        n_res_valid = 1'b1;
                        n_res_word  = mem_rd_data;
                        n_pc        = pc_inc;
                    end
                    OP_LOAD: begin
                        n_acc = mem_rd_data;
                        n_pc  = pc_inc;
                    end
                    OP_ADD: begin
                        alu_req.start = 1'b1;
                        alu_req.op    = ALU_ADD;
                        n_state       = S_WAIT;
                    end
                    OP_SUBTRACT: begin
                        alu_req.start = 1'b1;
                        alu_req.op    = ALU_SUB;
                        n_state       = S_WAIT;
                    end
                    OP_MULTIPLY: begin
                        alu_req.start = 1'b1;
                        alu_req.op    = ALU_MUL;
                        n_state       = S_WAIT;
                    end
                    OP_DIVIDE: begin
                        if (mem_rd_data == '0) begin
                            do_stop   = 1'b1;
                            stop_code = ST_DIV_ZERO;
                        end else begin
                            alu_req.start = 1'b1;
                            alu_req.op    = ALU_DIV;
                            n_state       = S_WAIT;
                        end
                    end
                    default: begin
                        do_stop   = 1'b1;
                        stop_code = ST_BAD_OPCODE;
                    end
                endcase
            end
            S_WAIT: begin
                if (alu_rsp.done) begin
                    n_state = S_RESP;
                    if (alu_rsp.over) begin
                        do_stop   = 1'b1;
                        stop_code = ST_OVERFLOW;
                    end else if (alu_rsp.under) begin
                        do_stop   = 1'b1;
                        stop_code = ST_UNDERFLOW;
                    end else begin
                        n_acc = alu_rsp.value;
                        n_pc  = pc_inc;
                    end
                end
            end
            S_RESP: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_valid  = r_res_valid;
                    n_o_word   = r_res_word;
                    n_o_acc    = r_acc;
                    n_o_pc     = r_pc;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_stop) begin
            n_stop       = stop_code;
            n_res_status = stop_code;
            n_state      = S_RESP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_acc     <= '0;
            r_pc      <= '0;
            r_stop    <= ST_OK;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_acc     <= n_acc;
            r_pc      <= n_pc;
            r_stop    <= n_stop;
            r_out_vld <= n_out_vld;
        end
        r_mode       <= n_mode;
        r_data       <= n_data;
        r_op         <= n_op;
        r_neg        <= n_neg;
        r_mag        <= n_mag;
        r_res_status <= n_res_status;
        r_res_valid  <= n_res_valid;
        r_res_word   <= n_res_word;
        r_o_status   <= n_o_status;
        r_o_valid    <= n_o_valid;
        r_o_word     <= n_o_word;
        r_o_acc      <= n_o_acc;
        r_o_pc       <= n_o_pc;
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_vld;
    assign o_out.status    = r_o_status;
    assign o_out.out_valid = r_o_valid;
    assign o_out.out_word  = r_o_word;
    assign o_out.acc_value = r_o_acc;
    assign o_out.pc_value  = r_o_pc;

`ifndef SYNTH
    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wr_en |-> (r_state == S_DISPATCH || r_state == S_DECODE))
        else $error("Word store written outside dispatch or decode.");

    a_pc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= PC_END)
        else $error("Instruction counter ran past the end of the store.");

    a_acc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc <= WORD_MAX) && (r_acc >= WORD_MIN))
        else $error("Accumulator left the word range.");

    a_alu_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> (r_state == S_WAIT))
        else $error("Arithmetic result arrived while the sequencer was not waiting.");
`endif

endmodule

`default_nettype wire
